// ----- rtl/piw_pkg.sv -----
// Shared types, constants and helper functions for the point-in-polygon winding block.
package piw_pkg;

	localparam int COORD_BITS    = 16;
	localparam int DIFF_BITS     = COORD_BITS + 1;
	localparam int PROD_BITS     = 2 * DIFF_BITS;
	localparam int WIND_BITS     = 12;
	localparam int CFG_IDX_BITS  = 1;
	localparam int CFG_DATA_BITS = COORD_BITS;

	localparam logic [CFG_IDX_BITS-1:0] REG_TEST_X = 1'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_TEST_Y = 1'd1;

	typedef logic [1:0] quad_t;

	localparam quad_t QUAD_PP = 2'd0;
	localparam quad_t QUAD_NP = 2'd1;
	localparam quad_t QUAD_NN = 2'd2;
	localparam quad_t QUAD_PN = 2'd3;

	typedef logic signed [DIFF_BITS-1:0] diff_t;
	typedef logic signed [PROD_BITS-1:0] prod_t;
	typedef logic signed [WIND_BITS-1:0] wind_t;

	typedef struct packed {
		logic signed [COORD_BITS-1:0] vertex_x;
		logic signed [COORD_BITS-1:0] vertex_y;
		logic                         last_vertex;
	} vertex_t;

	typedef struct packed {
		logic  inside_res;
		wind_t winding;
	} result_t;

	// A vertex relative to the test point, as handed from the front to the back.
	typedef struct packed {
		diff_t dx;
		diff_t dy;
		quad_t quad;
		logic  last;
	} rel_vertex_t;

	typedef enum logic [2:0] {
		STEP_NONE,
		STEP_INC,
		STEP_DEC,
		STEP_INC_IF_GE,
		STEP_DEC_IF_LT
	} step_t;

	function automatic quad_t quadrant(input diff_t dx, input diff_t dy);
		quad_t q;
		if (dy[DIFF_BITS-1]) begin
			q = dx[DIFF_BITS-1] ? QUAD_NN : QUAD_PN;
		end else begin
			q = dx[DIFF_BITS-1] ? QUAD_NP : QUAD_PP;
		end
		return q;
	endfunction

	// Classifies the quadrant step of an edge from quadrant pq to quadrant cq.
	function automatic step_t step_class(input quad_t pq, input quad_t cq);
		step_t s;
		if (pq == QUAD_PN && cq == QUAD_PP) begin
			s = STEP_INC;
		end else if (pq == QUAD_PP && cq == QUAD_PN) begin
			s = STEP_DEC;
		end else if ((pq == QUAD_NN && cq == QUAD_PP) || (pq == QUAD_PN && cq == QUAD_NP)) begin
			s = STEP_INC_IF_GE;
		end else if ((pq == QUAD_PP && cq == QUAD_NN) || (pq == QUAD_NP && cq == QUAD_PN)) begin
			s = STEP_DEC_IF_LT;
		end else begin
			s = STEP_NONE;
		end
		return s;
	endfunction

	function automatic wind_t step_delta(input step_t s, input logic ge);
		wind_t d;
		case (s)
			STEP_INC:       d = wind_t'(1);
			STEP_DEC:       d = wind_t'(-1);
			STEP_INC_IF_GE: d = ge ? wind_t'(1) : wind_t'(0);
			STEP_DEC_IF_LT: d = ge ? wind_t'(0) : wind_t'(-1);
			default:        d = wind_t'(0);
		endcase
		return d;
	endfunction

endpackage

// ----- rtl/point_in_polygon_winding.sv -----
// Point-in-polygon test by quadrant winding number over a stream of vertices.
// Throughput: one vertex per cycle; the back end's single product stage sets the pace,
// but holds a closing vertex while the result queue is full; results wait in that queue.
// Full and empty follow two small queues: vertices to the back end, results to the port.
// Reset clears the test point, the queues, the vertex tally and the winding count.
module point_in_polygon_winding #(
	parameter int MID_DEPTH = 4,
	parameter int RES_DEPTH = 2
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [piw_pkg::CFG_IDX_BITS-1:0]   cfg_index,
	input  logic [piw_pkg::CFG_DATA_BITS-1:0]  cfg_data,
	input  logic                               push,
	input  piw_pkg::vertex_t                   vertex,
	output logic                               full,
	input  logic                               pop,
	output piw_pkg::result_t                   result,
	output logic                               empty
);
	import piw_pkg::*;

	rel_vertex_t rel;
	rel_vertex_t head;
	logic        head_empty;
	logic        head_pop;
	logic        res_full;
	logic        res_push;
	result_t     res;

	piw_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.vertex    (vertex),
		.rel       (rel)
	);

	piw_queue #(
		.item_t (rel_vertex_t),
		.DEPTH  (MID_DEPTH)
	) u_mid_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.din    (rel),
		.full   (full),
		.pop    (head_pop),
		.dout   (head),
		.empty  (head_empty)
	);

	piw_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (head),
		.head_empty (head_empty),
		.head_pop   (head_pop),
		.res_full   (res_full),
		.res_push   (res_push),
		.res        (res)
	);

	piw_queue #(
		.item_t (result_t),
		.DEPTH  (RES_DEPTH)
	) u_res_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (res_push),
		.din    (res),
		.full   (res_full),
		.pop    (pop),
		.dout   (result),
		.empty  (empty)
	);
endmodule

// ----- rtl/piw_queue.sv -----
// Small first-in first-out queue built from flip-flops.
module piw_queue #(
	parameter type item_t = logic,
	parameter int  DEPTH  = 4
) (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  item_t din,
	output logic  full,
	input  logic  pop,
	output item_t dout,
	output logic  empty
);
	localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_BITS = $clog2(DEPTH + 1);
	localparam logic [PTR_BITS-1:0] LAST_PTR = PTR_BITS'(DEPTH - 1);
	localparam logic [CNT_BITS-1:0] FULL_CNT = CNT_BITS'(DEPTH);

	item_t               mem_q [DEPTH];
	logic [PTR_BITS-1:0] wr_ptr_q;
	logic [PTR_BITS-1:0] rd_ptr_q;
	logic [CNT_BITS-1:0] count_q;
	logic                do_push;
	logic                do_pop;

	assign full    = (count_q == FULL_CNT);
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign dout    = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end
endmodule

// ----- rtl/piw_front.sv -----
// Front end: holds the test point and turns each vertex into offsets and a quadrant.
module piw_front (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [piw_pkg::CFG_IDX_BITS-1:0]     cfg_index,
	input  logic [piw_pkg::CFG_DATA_BITS-1:0]    cfg_data,
	input  piw_pkg::vertex_t                     vertex,
	output piw_pkg::rel_vertex_t                 rel
);
	import piw_pkg::*;

	logic signed [COORD_BITS-1:0] test_x_q;
	logic signed [COORD_BITS-1:0] test_y_q;
	diff_t                        dx;
	diff_t                        dy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			test_x_q <= '0;
			test_y_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_TEST_X: test_x_q <= cfg_data;
				REG_TEST_Y: test_y_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign dx = {vertex.vertex_x[COORD_BITS-1], vertex.vertex_x} - {test_x_q[COORD_BITS-1], test_x_q};
	assign dy = {vertex.vertex_y[COORD_BITS-1], vertex.vertex_y} - {test_y_q[COORD_BITS-1], test_y_q};

	assign rel.dx   = dx;
	assign rel.dy   = dy;
	assign rel.quad = quadrant(dx, dy);
	assign rel.last = vertex.last_vertex;
endmodule

// ----- rtl/piw_back.sv -----
// Back end: edge products, winding update and the per-polygon result.
module piw_back (
	input  logic                  clk,
	input  logic                  arst_n,
	input  piw_pkg::rel_vertex_t  head,
	input  logic                  head_empty,
	output logic                  head_pop,
	input  logic                  res_full,
	output logic                  res_push,
	output piw_pkg::result_t      res
);
	import piw_pkg::*;

	diff_t       first_dx_q;
	diff_t       first_dy_q;
	quad_t       first_quad_q;
	diff_t       prev_dx_q;
	diff_t       prev_dy_q;
	quad_t       prev_quad_q;
	logic [1:0]  tally_q;
	wind_t       wind_q;

	logic        valid_s1;
	step_t       a_step_s1;
	prod_t       a_p1_s1;
	prod_t       a_p2_s1;
	step_t       b_step_s1;
	prod_t       b_p1_s1;
	prod_t       b_p2_s1;
	logic        first_s1;
	logic        last_s1;
	logic        short_s1;

	logic        consume;
	logic        load;
	logic        is_first;
	diff_t       f_dx;
	diff_t       f_dy;
	quad_t       f_quad;
	logic [1:0]  tally_inc;
	wind_t       wind_base;
	wind_t       wind_new;

	// A stage holding a closing vertex waits while the result queue is full.
	assign consume  = valid_s1 && !(last_s1 && res_full);
	assign load     = !head_empty && (!valid_s1 || consume);
	assign head_pop = load;

	assign is_first  = (tally_q == 2'd0);
	assign f_dx      = is_first ? head.dx : first_dx_q;
	assign f_dy      = is_first ? head.dy : first_dy_q;
	assign f_quad    = is_first ? head.quad : first_quad_q;
	assign tally_inc = (tally_q == 2'd3) ? 2'd3 : tally_q + 2'd1;

	always_ff @(posedge clk) begin
		if (load) begin
			a_step_s1 <= is_first ? STEP_NONE : step_class(prev_quad_q, head.quad);
			a_p1_s1   <= prod_t'(prev_dx_q) * prod_t'(head.dy);
			a_p2_s1   <= prod_t'(prev_dy_q) * prod_t'(head.dx);
			b_step_s1 <= head.last ? step_class(head.quad, f_quad) : STEP_NONE;
			b_p1_s1   <= prod_t'(head.dx) * prod_t'(f_dy);
			b_p2_s1   <= prod_t'(head.dy) * prod_t'(f_dx);
			first_s1  <= is_first;
			last_s1   <= head.last;
			short_s1  <= (tally_q < 2'd2);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1     <= 1'b0;
			first_dx_q   <= '0;
			first_dy_q   <= '0;
			first_quad_q <= QUAD_PP;
			prev_dx_q    <= '0;
			prev_dy_q    <= '0;
			prev_quad_q  <= QUAD_PP;
			tally_q      <= 2'd0;
			wind_q       <= '0;
		end else begin
			if (load) begin
				valid_s1 <= 1'b1;
			end else if (consume) begin
				valid_s1 <= 1'b0;
			end
			if (load) begin
				if (is_first) begin
					first_dx_q   <= head.dx;
					first_dy_q   <= head.dy;
					first_quad_q <= head.quad;
				end
				prev_dx_q   <= head.dx;
				prev_dy_q   <= head.dy;
				prev_quad_q <= head.quad;
				tally_q     <= head.last ? 2'd0 : tally_inc;
			end
			if (consume) begin
				wind_q <= last_s1 ? '0 : wind_new;
			end
		end
	end

	assign wind_base = first_s1 ? '0 : wind_q;
	assign wind_new  = wind_base + step_delta(a_step_s1, a_p1_s1 >= a_p2_s1)
		+ step_delta(b_step_s1, b_p1_s1 >= b_p2_s1);

	assign res_push       = consume && last_s1;
	assign res.inside_res = !short_s1 && (wind_new != '0);
	assign res.winding    = short_s1 ? '0 : wind_new;
endmodule

// ----- tb/winding_checker.sv -----
// Watches the vertex, result and register ports, predicts each winding result and compares.
module winding_checker (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [piw_pkg::CFG_IDX_BITS-1:0]  cfg_index,
	input  logic [piw_pkg::CFG_DATA_BITS-1:0] cfg_data,
	input  logic                              push,
	input  piw_pkg::vertex_t                  vertex,
	input  logic                              full,
	input  logic                              pop,
	input  piw_pkg::result_t                  result,
	input  logic                              empty,
	input  logic                              run_done,
	output int                                mismatches,
	output int                                awaited,
	output int                                vertex_total,
	output int                                polygon_total,
	output int                                short_total,
	output int                                inside_total
);
	import piw_pkg::*;

	logic signed [COORD_BITS-1:0] point_x;
	logic signed [COORD_BITS-1:0] point_y;
	diff_t                        first_dx;
	diff_t                        first_dy;
	quad_t                        first_q;
	diff_t                        prev_dx;
	diff_t                        prev_dy;
	quad_t                        prev_q;
	logic [WIND_BITS-1:0]         wind;
	logic [1:0]                   seen;
	result_t                      expected_results[$];

	function automatic quad_t quad_of(input diff_t dx, input diff_t dy);
		if (dy < 0) begin
			return (dx < 0) ? QUAD_NN : QUAD_PN;
		end
		return (dx < 0) ? QUAD_NP : QUAD_PP;
	endfunction

	function automatic logic [WIND_BITS-1:0] wind_after_edge(input logic [WIND_BITS-1:0] w,
			input diff_t pdx, input diff_t pdy, input quad_t pq,
			input diff_t cdx, input diff_t cdy, input quad_t cq);
		prod_t lhs;
		prod_t rhs;
		int    turn;
		lhs = pdx * cdy;
		rhs = pdy * cdx;
		turn = int'(cq) - int'(pq);
		case (turn)
			-3: w = w + 1'b1;
			3: w = w - 1'b1;
			-2: begin
				if (lhs >= rhs) w = w + 1'b1;
			end
			2: begin
				if (lhs < rhs) w = w - 1'b1;
			end
			default: ;
		endcase
		return w;
	endfunction

	task automatic flag_mismatch(input string what);
		mismatches++;
		$display("[%0t] mismatch: %s", $time, what);
	endtask

	task automatic predict_winding(input vertex_t v);
		diff_t   dx;
		diff_t   dy;
		quad_t   q;
		result_t r;
		dx = {v.vertex_x[COORD_BITS-1], v.vertex_x} - {point_x[COORD_BITS-1], point_x};
		dy = {v.vertex_y[COORD_BITS-1], v.vertex_y} - {point_y[COORD_BITS-1], point_y};
		q = quad_of(dx, dy);
		if (seen == 2'd0) begin
			first_dx = dx;
			first_dy = dy;
			first_q = q;
			wind = '0;
		end else begin
			wind = wind_after_edge(wind, prev_dx, prev_dy, prev_q, dx, dy, q);
		end
		prev_dx = dx;
		prev_dy = dy;
		prev_q = q;
		if (seen != 2'd3) seen = seen + 1'b1;
		if (v.last_vertex) begin
			// The closing edge runs from this vertex back to the first one.
			wind = wind_after_edge(wind, dx, dy, q, first_dx, first_dy, first_q);
			if (seen != 2'd3) begin
				r.inside_res = 1'b0;
				r.winding = '0;
				short_total++;
			end else begin
				r.inside_res = (wind != '0);
				r.winding = wind;
				if (r.inside_res) inside_total++;
			end
			expected_results.insert(expected_results.size(), r);
			polygon_total++;
			wind = '0;
			seen = '0;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		result_t want;
		if (!arst_n) begin
			point_x = '0;
			point_y = '0;
			first_dx = '0;
			first_dy = '0;
			first_q = QUAD_PP;
			prev_dx = '0;
			prev_dy = '0;
			prev_q = QUAD_PP;
			wind = '0;
			seen = '0;
			expected_results.delete();
			mismatches = 0;
			vertex_total = 0;
			polygon_total = 0;
			short_total = 0;
			inside_total = 0;
			awaited <= 0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == REG_TEST_X) point_x = cfg_data;
				else if (cfg_index == REG_TEST_Y) point_y = cfg_data;
			end
			if (pop && !empty) begin
				if (expected_results.size() == 0) begin
					flag_mismatch($sformatf("result %0b/%0d with none expected",
						result.inside_res, result.winding));
				end else begin
					want = expected_results.pop_front();
					if (result.inside_res !== want.inside_res) begin
						flag_mismatch($sformatf("inside_res got %0b, expected %0b",
							result.inside_res, want.inside_res));
					end
					if (result.winding !== want.winding) begin
						flag_mismatch($sformatf("winding got %0d, expected %0d",
							result.winding, want.winding));
					end
				end
			end
			if (push && !full) begin
				vertex_total++;
				predict_winding(vertex);
			end
			awaited <= expected_results.size();
		end
	end

	always @(posedge run_done) begin
		if (expected_results.size() != 0) begin
			flag_mismatch($sformatf("%0d results never arrived", expected_results.size()));
		end
	end

endmodule

// ----- tb/tb_top.sv -----
// Testbench top: clock, reset, vertex stimulus, register writes and the final verdict.
module tb_top;
	import piw_pkg::*;

	localparam int CYCLE_LIMIT = 600000;
	localparam int SETTLE      = 10;
	localparam int CHUNK_ITEMS = 200;

	logic                      clk = 1'b0;
	logic                      arst_n;
	logic                      cfg_we;
	logic [CFG_IDX_BITS-1:0]   cfg_index;
	logic [CFG_DATA_BITS-1:0]  cfg_data;
	logic                      push;
	vertex_t                   vertex;
	logic                      full;
	logic                      pop;
	result_t                   result;
	logic                      empty;
	logic                      run_done;

	int mismatches;
	int awaited;
	int vertex_total;
	int polygon_total;
	int short_total;
	int inside_total;

	int tx_idle_pct;
	int rx_idle_pct;
	bit hold_request;
	int hold_left;
	int cycles;
	int settings_used;
	int cur_x;
	int cur_y;

	always #5 clk = ~clk;

	point_in_polygon_winding uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.push      (push),
		.vertex    (vertex),
		.full      (full),
		.pop       (pop),
		.result    (result),
		.empty     (empty)
	);

	winding_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.push          (push),
		.vertex        (vertex),
		.full          (full),
		.pop           (pop),
		.result        (result),
		.empty         (empty),
		.run_done      (run_done),
		.mismatches    (mismatches),
		.awaited       (awaited),
		.vertex_total  (vertex_total),
		.polygon_total (polygon_total),
		.short_total   (short_total),
		.inside_total  (inside_total)
	);

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("run stopped at the cycle limit of %0d", CYCLE_LIMIT);
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// Result side: random pops, or a long stretch with none when a hold is requested.
	always @(negedge clk) begin
		if (!arst_n) begin
			pop <= 1'b0;
		end else if (hold_request) begin
			hold_request = 1'b0;
			hold_left = 60;
			pop <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left--;
			pop <= 1'b0;
		end else begin
			pop <= ($urandom_range(0, 99) >= rx_idle_pct);
		end
	end

	// Called at a falling edge; returns at the falling edge after the item is taken.
	task automatic send_vertex(input int x, input int y, input bit last);
		vertex_t v;
		v.vertex_x = COORD_BITS'(x);
		v.vertex_y = COORD_BITS'(y);
		v.last_vertex = last;
		while ($urandom_range(0, 99) < tx_idle_pct) begin
			push <= 1'b0;
			@(negedge clk);
		end
		push <= 1'b1;
		vertex <= v;
		do @(posedge clk); while (full);
		@(negedge clk);
	endtask

	task automatic drain();
		push <= 1'b0;
		do @(posedge clk); while (awaited != 0);
		repeat (SETTLE) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx, input int value);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= CFG_DATA_BITS'(value);
		if (idx == REG_TEST_X) cur_x = value;
		else cur_y = value;
		@(negedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	task automatic write_point(input int x, input int y);
		write_reg(REG_TEST_X, x);
		write_reg(REG_TEST_Y, y);
		settings_used++;
	endtask

	task automatic send_random_polygon(output int count);
		int    kind;
		int    n;
		int    laps;
		int    radius;
		int    per;
		int    ox;
		int    oy;
		bit    ccw;
		quad_t q;
		kind = $urandom_range(0, 99);
		count = 0;
		if (kind < 45) begin
			// Walk around the point quadrant by quadrant so the count really moves.
			laps = $urandom_range(1, 3);
			ccw = $urandom_range(0, 1);
			case ($urandom_range(0, 2))
				0: radius = 4;
				1: radius = 400;
				default: radius = 30000;
			endcase
			for (int k = 0; k < laps * 4; k++) begin
				q = ccw ? quad_t'(k % 4) : quad_t'(3 - k % 4);
				per = $urandom_range(1, 2);
				for (int j = 0; j < per; j++) begin
					ox = $urandom_range(0, radius);
					oy = $urandom_range(0, radius);
					if (q == QUAD_NP || q == QUAD_NN) ox = -ox - 1;
					if (q == QUAD_NN || q == QUAD_PN) oy = -oy - 1;
					count++;
					send_vertex(cur_x + ox, cur_y + oy, (k == laps * 4 - 1) && (j == per - 1));
				end
			end
		end else if (kind < 70) begin
			// Tight cloud: many zero offsets and collinear edges.
			n = $urandom_range(3, 10);
			for (int k = 0; k < n; k++) begin
				ox = $urandom_range(0, 8);
				oy = $urandom_range(0, 8);
				send_vertex(cur_x + ox - 4, cur_y + oy - 4, k == n - 1);
			end
			count = n;
		end else if (kind < 85) begin
			n = $urandom_range(3, 8);
			for (int k = 0; k < n; k++) begin
				send_vertex($urandom, $urandom, k == n - 1);
			end
			count = n;
		end else begin
			n = $urandom_range(1, 2);
			for (int k = 0; k < n; k++) begin
				if ($urandom_range(0, 1)) send_vertex($urandom, $urandom, k == n - 1);
				else send_vertex(cur_x + $urandom_range(0, 6) - 3, cur_y - 1, k == n - 1);
			end
			count = n;
		end
	endtask

	task automatic random_chunk(input int items);
		int done;
		int n;
		done = 0;
		while (done < items) begin
			send_random_polygon(n);
			done += n;
		end
	endtask

	// Collinear diagonal pairs through the point each add one to the count.
	task automatic wrap_polygon(input int pairs);
		for (int k = 0; k < pairs; k++) begin
			send_vertex(cur_x + 1, cur_y + 1, 1'b0);
			send_vertex(cur_x - 1, cur_y - 1, k == pairs - 1);
		end
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		push = 1'b0;
		vertex = '0;
		pop = 1'b0;
		run_done = 1'b0;
		hold_request = 1'b0;
		hold_left = 0;
		cycles = 0;
		settings_used = 1;
		cur_x = 0;
		cur_y = 0;
		tx_idle_pct = 15;
		rx_idle_pct = 60;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Short polygons of one and two vertices.
		send_vertex(0, 0, 1'b1);
		send_vertex(5, 5, 1'b0);
		send_vertex(-5, -5, 1'b1);
		// Unit squares around the point, both directions.
		send_vertex(1, 1, 1'b0);
		send_vertex(-1, 1, 1'b0);
		send_vertex(-1, -1, 1'b0);
		send_vertex(1, -1, 1'b1);
		send_vertex(1, -1, 1'b0);
		send_vertex(-1, -1, 1'b0);
		send_vertex(-1, 1, 1'b0);
		send_vertex(1, 1, 1'b1);
		// Diagonal steps with equal cross products.
		send_vertex(1, 1, 1'b0);
		send_vertex(-1, -1, 1'b0);
		send_vertex(2, 2, 1'b1);
		// Coordinate extremes.
		send_vertex(32767, 32767, 1'b0);
		send_vertex(-32768, 32767, 1'b0);
		send_vertex(-32768, -32768, 1'b0);
		send_vertex(32767, -32768, 1'b1);
		// The test point moves while a polygon is open.
		send_vertex(100, 100, 1'b0);
		send_vertex(-100, 100, 1'b0);
		drain();
		write_reg(REG_TEST_X, 200);
		send_vertex(-100, -100, 1'b0);
		send_vertex(300, -50, 1'b1);
		// Largest differences and products.
		drain();
		write_point(32767, -32768);
		send_vertex(-32768, 32767, 1'b0);
		send_vertex(32767, -32768, 1'b0);
		send_vertex(-32768, -32768, 1'b1);

		drain();
		write_point(-32768, -32768);
		random_chunk(CHUNK_ITEMS);
		// Stall the result side while single-vertex polygons keep arriving.
		drain();
		@(posedge clk);
		hold_request = 1'b1;
		@(negedge clk);
		repeat (24) send_vertex($urandom, $urandom, 1'b1);
		drain();
		write_point(32767, 32767);
		random_chunk(CHUNK_ITEMS);

		tx_idle_pct = 60;
		rx_idle_pct = 15;
		drain();
		write_point(int'($urandom_range(0, 65535)) - 32768, int'($urandom_range(0, 65535)) - 32768);
		random_chunk(CHUNK_ITEMS);
		drain();
		write_point(-32768, 32767);
		random_chunk(CHUNK_ITEMS);

		tx_idle_pct = 0;
		rx_idle_pct = 0;
		drain();
		write_point(-5, 9);
		wrap_polygon(150);
		drain();
		write_point(int'($urandom_range(0, 65535)) - 32768, int'($urandom_range(0, 65535)) - 32768);
		random_chunk(CHUNK_ITEMS);
		drain();
		write_point(0, 0);
		random_chunk(CHUNK_ITEMS);

		drain();
		run_done <= 1'b1;
		@(negedge clk);
		$display("Covered %0d vertices in %0d polygons: %0d short, %0d enclosing the point.",
			vertex_total, polygon_total, short_total, inside_total);
		$display("Used %0d test points, three idle mixes, a long result stall and a long winding run.",
			settings_used);
		if (mismatches == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule

// ----- files.f -----
rtl/piw_pkg.sv
rtl/piw_queue.sv
rtl/piw_front.sv
rtl/piw_back.sv
rtl/point_in_polygon_winding.sv
tb/winding_checker.sv
tb/tb_top.sv
